[src/assert_macros.svh]
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, quiet while rst_n is low
`define TLG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("tlg assertion failed");

// next-cycle implication, sampled on clk, quiet while rst_n is low
`define TLG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("tlg assertion failed");

`endif

[src/tlg_pkg.sv]
package tlg_pkg;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_ADVANCE = 2'd2,
        OP_NONE    = 2'd3
    } tlg_op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR_MOD,
        ST_RD_OUT,
        ST_ADV_PREV,
        ST_ADV_FIRST,
        ST_ADV_ROW
    } tlg_state_t;

    localparam logic       REG_NUM_ROWS = 1'b0;
    localparam logic       REG_NUM_COLS = 1'b1;
    localparam logic [7:0] SIZE_RESET   = 8'd100;

    localparam logic [3:0] COUNT_BIRTH  = 4'd3;
    localparam logic [3:0] COUNT_KEEP   = 4'd2;

endpackage

[src/tlg_row_eval.sv]
module tlg_row_eval #(
    parameter int MAX_COLS = 128
) (
    input  logic [MAX_COLS-1:0] prev_row,
    input  logic [MAX_COLS-1:0] cur_row,
    input  logic [MAX_COLS-1:0] next_row,
    input  logic [7:0]          num_cols,
    output logic [MAX_COLS-1:0] new_row
);

    localparam int CW = $clog2(MAX_COLS);

    logic [CW-1:0] last_col;

    assign last_col = CW'(num_cols - 8'd1);

    for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
        logic       p_l, p_r, c_l, c_r, n_l, n_r;
        logic [3:0] count;
        logic       in_use;

        // wrap to the last column in use on the left edge
        if (c == 0) begin : g_left_wrap
            assign p_l = prev_row[last_col];
            assign c_l = cur_row[last_col];
            assign n_l = next_row[last_col];
        end
        else begin : g_left
            assign p_l = prev_row[c-1];
            assign c_l = cur_row[c-1];
            assign n_l = next_row[c-1];
        end

        // top column can only be in use as the last one
        if (c == MAX_COLS - 1) begin : g_right_wrap
            assign p_r = prev_row[0];
            assign c_r = cur_row[0];
            assign n_r = next_row[0];
        end
        else begin : g_right
            assign p_r = (CW'(c) == last_col) ? prev_row[0] : prev_row[c+1];
            assign c_r = (CW'(c) == last_col) ? cur_row[0]  : cur_row[c+1];
            assign n_r = (CW'(c) == last_col) ? next_row[0] : next_row[c+1];
        end

        assign count = 4'(p_l) + 4'(prev_row[c]) + 4'(p_r)
                     + 4'(c_l) + 4'(c_r)
                     + 4'(n_l) + 4'(next_row[c]) + 4'(n_r);

        assign in_use = (c < 32'(num_cols));

        always_comb
        begin
            if (!in_use) begin
                new_row[c] = cur_row[c];
            end
            else if (count == tlg_pkg::COUNT_BIRTH) begin
                new_row[c] = 1'b1;
            end
            else if (count == tlg_pkg::COUNT_KEEP) begin
                new_row[c] = cur_row[c];
            end
            else begin
                new_row[c] = 1'b0;
            end
        end
    end

endmodule

[src/toroidal_life_generation_engine_unit.sv]
// channel   direction  ports                                  accepted when
// input     in         in_valid/in_ready, operation,row,...   in_valid & in_ready
// output    out        out_valid/out_ready, cell_alive,...    out_valid & out_ready
// config    in         cfg_write, cfg_index, cfg_data         cfg_write
//
// grid held one row per memory word, updated in place a row at a time
// write and read words read the row, then modify or present it
// advance reads the last and first rows, then reads and writes one row word per cycle
// after reset a clearing pass over all MAX_ROWS words holds in_ready low
// a read word waits in place while the output word is not taken; others run on
module toroidal_life_generation_engine_unit #(
    parameter int MAX_ROWS = 128,
    parameter int MAX_COLS = 128
) (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] operation,
    input  logic [6:0] row,
    input  logic [6:0] col,
    input  logic       alive,

    output logic       out_valid,
    input  logic       out_ready,
    output logic       cell_alive,
    output logic [6:0] cell_row,
    output logic [6:0] cell_col,

    input  logic       cfg_write,
    input  logic [0:0] cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int AW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);

    tlg_pkg::tlg_state_t state_reg, state_next;
    logic [AW-1:0]       clear_cnt_reg, clear_cnt_next;
    logic [7:0]          row_cnt_reg, row_cnt_next;
    logic [7:0]          num_rows_reg, num_cols_reg;
    logic [7:0]          nr, nc;

    tlg_pkg::tlg_op_t    op_reg;
    logic [6:0]          row_reg, col_reg;
    logic                alive_reg, inside_reg;
    logic                item_load;

    logic [MAX_COLS-1:0] prev_reg, prev_next;
    logic [MAX_COLS-1:0] cur_reg, cur_next;
    logic [MAX_COLS-1:0] first_reg, first_next;
    logic [MAX_COLS-1:0] next_row, new_row;

    logic                out_valid_reg, out_valid_next;
    logic                cell_alive_reg, cell_alive_next;
    logic [6:0]          cell_row_reg, cell_row_next;
    logic [6:0]          cell_col_reg, cell_col_next;

    logic [MAX_COLS-1:0] mem [MAX_ROWS];
    logic [MAX_COLS-1:0] rdata_reg;
    logic                ren, wen;
    logic [AW-1:0]       raddr, waddr;
    logic [MAX_COLS-1:0] wdata;
    logic [8:0]          ahead;

    // sizes in use: zero counts as one, clipped to the bound
    always_comb
    begin
        if (num_rows_reg == 8'd0) begin
            nr = 8'd1;
        end
        else if (32'(num_rows_reg) > MAX_ROWS) begin
            nr = 8'(MAX_ROWS);
        end
        else begin
            nr = num_rows_reg;
        end

        if (num_cols_reg == 8'd0) begin
            nc = 8'd1;
        end
        else if (32'(num_cols_reg) > MAX_COLS) begin
            nc = 8'(MAX_COLS);
        end
        else begin
            nc = num_cols_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wen) begin
            mem[waddr] <= wdata;
        end
        if (ren) begin
            rdata_reg <= mem[raddr];
        end
    end

    // last row wraps onto the saved copy of the old first row
    assign next_row = (row_cnt_reg == nr - 8'd1) ? first_reg : rdata_reg;
    assign ahead    = 9'(row_cnt_reg) + 9'd2;

    tlg_row_eval #(
        .MAX_COLS (MAX_COLS)
    ) u_row_eval (
        .prev_row (prev_reg),
        .cur_row  (cur_reg),
        .next_row (next_row),
        .num_cols (nc),
        .new_row  (new_row)
    );

    always_comb
    begin
        state_next      = state_reg;
        clear_cnt_next  = clear_cnt_reg;
        row_cnt_next    = row_cnt_reg;
        prev_next       = prev_reg;
        cur_next        = cur_reg;
        first_next      = first_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        cell_alive_next = cell_alive_reg;
        cell_row_next   = cell_row_reg;
        cell_col_next   = cell_col_reg;
        in_ready        = 1'b0;
        item_load       = 1'b0;
        ren             = 1'b0;
        raddr           = '0;
        wen             = 1'b0;
        waddr           = '0;
        wdata           = new_row;

        unique case (state_reg)
            tlg_pkg::ST_CLEAR:
            begin
                wen   = 1'b1;
                waddr = clear_cnt_reg;
                wdata = '0;
                if (clear_cnt_reg == AW'(MAX_ROWS - 1)) begin
                    state_next = tlg_pkg::ST_IDLE;
                end
                else begin
                    clear_cnt_next = clear_cnt_reg + AW'(1);
                end
            end

            tlg_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    item_load = 1'b1;
                    ren       = 1'b1;
                    unique case (tlg_pkg::tlg_op_t'(operation))
                        tlg_pkg::OP_ADVANCE:
                        begin
                            raddr      = AW'(nr - 8'd1);
                            state_next = tlg_pkg::ST_ADV_PREV;
                        end
                        tlg_pkg::OP_READ:
                        begin
                            raddr      = AW'(row);
                            state_next = tlg_pkg::ST_RD_OUT;
                        end
                        default:
                        begin
                            raddr      = AW'(row);
                            state_next = tlg_pkg::ST_WR_MOD;
                        end
                    endcase
                end
            end

            tlg_pkg::ST_WR_MOD:
            begin
                wen   = inside_reg && (op_reg == tlg_pkg::OP_WRITE);
                waddr = AW'(row_reg);
                wdata = rdata_reg;
                wdata[CW'(col_reg)] = alive_reg;
                state_next = tlg_pkg::ST_IDLE;
            end

            tlg_pkg::ST_RD_OUT:
            begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next  = 1'b1;
                    cell_alive_next = inside_reg && rdata_reg[CW'(col_reg)];
                    cell_row_next   = row_reg;
                    cell_col_next   = col_reg;
                    state_next      = tlg_pkg::ST_IDLE;
                end
            end

            tlg_pkg::ST_ADV_PREV:
            begin
                prev_next  = rdata_reg;
                ren        = 1'b1;
                raddr      = '0;
                state_next = tlg_pkg::ST_ADV_FIRST;
            end

            tlg_pkg::ST_ADV_FIRST:
            begin
                cur_next     = rdata_reg;
                first_next   = rdata_reg;
                row_cnt_next = 8'd0;
                if (nr > 8'd1) begin
                    ren   = 1'b1;
                    raddr = AW'(8'd1);
                end
                state_next = tlg_pkg::ST_ADV_ROW;
            end

            tlg_pkg::ST_ADV_ROW:
            begin
                // rows below are still old, so the update goes in place
                wen       = 1'b1;
                waddr     = AW'(row_cnt_reg);
                wdata     = new_row;
                prev_next = cur_reg;
                cur_next  = next_row;
                if (ahead < 9'(nr)) begin
                    ren   = 1'b1;
                    raddr = AW'(ahead);
                end
                if (row_cnt_reg == nr - 8'd1) begin
                    state_next = tlg_pkg::ST_IDLE;
                end
                else begin
                    row_cnt_next = row_cnt_reg + 8'd1;
                end
            end

            default:
            begin
                state_next = tlg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= tlg_pkg::ST_CLEAR;
            clear_cnt_reg <= '0;
            row_cnt_reg   <= 8'd0;
            out_valid_reg <= 1'b0;
            num_rows_reg  <= tlg_pkg::SIZE_RESET;
            num_cols_reg  <= tlg_pkg::SIZE_RESET;
        end
        else begin
            state_reg     <= state_next;
            clear_cnt_reg <= clear_cnt_next;
            row_cnt_reg   <= row_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write) begin
                unique case (cfg_index)
                    tlg_pkg::REG_NUM_ROWS: num_rows_reg <= cfg_data;
                    tlg_pkg::REG_NUM_COLS: num_cols_reg <= cfg_data;
                    default:               num_rows_reg <= num_rows_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg       <= prev_next;
        cur_reg        <= cur_next;
        first_reg      <= first_next;
        cell_alive_reg <= cell_alive_next;
        cell_row_reg   <= cell_row_next;
        cell_col_reg   <= cell_col_next;
        if (item_load) begin
            op_reg     <= tlg_pkg::tlg_op_t'(operation);
            row_reg    <= row;
            col_reg    <= col;
            alive_reg  <= alive;
            inside_reg <= (8'(row) < nr) && (8'(col) < nc);
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_alive = cell_alive_reg;
    assign cell_row   = cell_row_reg;
    assign cell_col   = cell_col_reg;

endmodule

[src/tlg_checker.sv]
`include "assert_macros.svh"

module tlg_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] operation,
    input logic       out_valid,
    input logic       out_ready,
    input logic       cell_alive,
    input logic [6:0] cell_row,
    input logic [6:0] cell_col
);

    // a result word that is not taken stays as it is
    `TLG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(cell_alive) && $stable(cell_row) && $stable(cell_col))

    // one word at a time: busy right after taking one
    `TLG_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

    // a read with the output free goes through ST_RD_OUT, then shows its result
    `TLG_ASSERT_IMPL(a_read_result, in_valid && in_ready && (operation == tlg_pkg::OP_READ) && !out_valid, ##2 out_valid)

    // a new result comes with the input side free again
    `TLG_ASSERT_IMPL(a_result_frees_input, $rose(out_valid), in_ready)

endmodule

bind toroidal_life_generation_engine_unit tlg_checker u_tlg_checker (.*);

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int GRID_MAX = 128;

    typedef struct {
        tlg_pkg::tlg_op_t op;
        logic [6:0]       r;
        logic [6:0]       c;
        logic             v;
    } life_cmd_t;

    typedef struct {
        logic       alive;
        logic [6:0] r;
        logic [6:0] c;
    } cell_report_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] operation = tlg_pkg::OP_NONE;
    logic [6:0] row = '0;
    logic [6:0] col = '0;
    logic       alive = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       cell_alive;
    logic [6:0] cell_row;
    logic [6:0] cell_col;
    logic       cfg_write = 1'b0;
    logic [0:0] cfg_index = tlg_pkg::REG_NUM_ROWS;
    logic [7:0] cfg_data = '0;

    toroidal_life_generation_engine_unit #(
        .MAX_ROWS(GRID_MAX),
        .MAX_COLS(GRID_MAX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .row(row),
        .col(col),
        .alive(alive),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cell_alive(cell_alive),
        .cell_row(cell_row),
        .cell_col(cell_col),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // own copy of the grid and of the size registers
    logic         life_grid [0:GRID_MAX-1][0:GRID_MAX-1];
    logic         prior_grid [0:GRID_MAX-1][0:GRID_MAX-1];
    logic [7:0]   rows_reg = tlg_pkg::SIZE_RESET;
    logic [7:0]   cols_reg = tlg_pkg::SIZE_RESET;

    life_cmd_t    cmd_queue [$];
    cell_report_t read_replies [$];
    int           mismatches = 0;
    int           in_gap = 0;
    int           out_hold = 0;
    bit           in_taken = 1'b0;
    bit           calm = 1'b0;

    initial
    begin
        for (int r = 0; r < GRID_MAX; r++)
            for (int c = 0; c < GRID_MAX; c++)
                life_grid[r][c] = 1'b0;
    end

    function automatic int span(input logic [7:0] v);
        if (v == 0)
            return 1;
        if (v > GRID_MAX)
            return GRID_MAX;
        return int'(v);
    endfunction

    task automatic life_step_generation();
        int nr;
        int nc;
        int count;
        int rr;
        int cc;
        nr = span(rows_reg);
        nc = span(cols_reg);
        prior_grid = life_grid;
        for (int r = 0; r < nr; r++)
        begin
            for (int c = 0; c < nc; c++)
            begin
                count = 0;
                // wrapped neighbours may repeat on tiny grids; each reach counts
                for (int dr = 0; dr < 3; dr++)
                begin
                    for (int dc = 0; dc < 3; dc++)
                    begin
                        if (!(dr == 1 && dc == 1))
                        begin
                            rr = (r + nr + dr - 1) % nr;
                            cc = (c + nc + dc - 1) % nc;
                            count += prior_grid[rr][cc];
                        end
                    end
                end
                if (count == tlg_pkg::COUNT_BIRTH)
                    life_grid[r][c] = 1'b1;
                else if (count != tlg_pkg::COUNT_KEEP)
                    life_grid[r][c] = 1'b0;
            end
        end
    endtask

    task automatic life_apply(input life_cmd_t cmd);
        int           nr;
        int           nc;
        bit           in_grid;
        cell_report_t rep;
        nr = span(rows_reg);
        nc = span(cols_reg);
        in_grid = (int'(cmd.r) < nr) && (int'(cmd.c) < nc);
        case (cmd.op)
            tlg_pkg::OP_WRITE:
            begin
                if (in_grid)
                    life_grid[cmd.r][cmd.c] = cmd.v;
            end
            tlg_pkg::OP_READ:
            begin
                rep.alive = in_grid ? life_grid[cmd.r][cmd.c] : 1'b0;
                rep.r = cmd.r;
                rep.c = cmd.c;
                read_replies.push_back(rep);
            end
            tlg_pkg::OP_ADVANCE:
                life_step_generation();
            default: ;
        endcase
    endtask

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // accept side: predict on every accepted input word, check every output word
    always @(posedge clk)
    begin : watch
        cell_report_t want;
        in_taken = in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
            life_apply('{op: tlg_pkg::tlg_op_t'(operation), r: row, c: col, v: alive});
        if (rst_n && out_valid && out_ready)
        begin
            if (read_replies.size() == 0)
                flag_mismatch($sformatf("unexpected word row %0d col %0d", cell_row, cell_col));
            else
            begin
                want = read_replies.pop_front();
                if (cell_alive !== want.alive)
                    flag_mismatch($sformatf("cell_alive %b, want %b at row %0d col %0d",
                        cell_alive, want.alive, want.r, want.c));
                if (cell_row !== want.r)
                    flag_mismatch($sformatf("cell_row %0d, want %0d", cell_row, want.r));
                if (cell_col !== want.c)
                    flag_mismatch($sformatf("cell_col %0d, want %0d", cell_col, want.c));
            end
        end
    end

    always @(negedge clk)
    begin : feed
        life_cmd_t nxt;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap = in_gap - 1;
            end
            else if (cmd_queue.size() != 0)
            begin
                nxt = cmd_queue.pop_front();
                in_valid <= 1'b1;
                operation <= nxt.op;
                row <= nxt.r;
                col <= nxt.c;
                alive <= nxt.v;
                // gap follows once this word is taken
                if (!calm && $urandom_range(0, 3) == 0)
                    in_gap = $urandom_range(1, 16);
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (out_hold > 0)
        begin
            out_ready <= 1'b0;
            out_hold = out_hold - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0)
                out_hold = $urandom_range(1, 16);
        end
    end

    function automatic void add_cmd(input tlg_pkg::tlg_op_t op, input int r, input int c,
                                    input bit v);
        life_cmd_t cmd;
        cmd.op = op;
        cmd.r = r[6:0];
        cmd.c = c[6:0];
        cmd.v = v;
        cmd_queue.push_back(cmd);
    endfunction

    // mostly well-formed traffic inside the grid in use, some stray words
    task automatic queue_random(input int count);
        int nr;
        int nc;
        int pick;
        nr = span(rows_reg);
        nc = span(cols_reg);
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                add_cmd(tlg_pkg::OP_WRITE, $urandom_range(0, nr - 1),
                    $urandom_range(0, nc - 1), $urandom_range(0, 2) != 0);
            else if (pick < 75)
                add_cmd(tlg_pkg::OP_READ, $urandom_range(0, nr - 1),
                    $urandom_range(0, nc - 1), 1'b0);
            else if (pick < 85)
                add_cmd(tlg_pkg::OP_ADVANCE, $urandom_range(0, 127), $urandom_range(0, 127),
                    $urandom_range(0, 1));
            else if (pick < 95)
                add_cmd($urandom_range(0, 1) ? tlg_pkg::OP_READ : tlg_pkg::OP_WRITE,
                    $urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 1));
            else
                add_cmd(tlg_pkg::OP_NONE, $urandom_range(0, 127), $urandom_range(0, 127),
                    $urandom_range(0, 1));
        end
    endtask

    // everything taken and answered, then let an advance run out
    task automatic drain_grid();
        while (cmd_queue.size() != 0 || in_valid || read_replies.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic set_size(input int rows_v, input int cols_v);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= tlg_pkg::REG_NUM_ROWS;
        cfg_data <= rows_v[7:0];
        @(negedge clk);
        cfg_index <= tlg_pkg::REG_NUM_COLS;
        cfg_data <= cols_v[7:0];
        @(negedge clk);
        cfg_write <= 1'b0;
        rows_reg = rows_v[7:0];
        cols_reg = cols_v[7:0];
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // corners of the reset-size grid
        add_cmd(tlg_pkg::OP_WRITE, 0, 0, 1'b1);
        add_cmd(tlg_pkg::OP_WRITE, 99, 99, 1'b1);
        add_cmd(tlg_pkg::OP_READ, 0, 0, 1'b0);
        add_cmd(tlg_pkg::OP_READ, 99, 99, 1'b0);
        // outside the size in use, a no-op, then the corner read and cleared
        add_cmd(tlg_pkg::OP_WRITE, 127, 127, 1'b1);
        add_cmd(tlg_pkg::OP_READ, 127, 127, 1'b0);
        add_cmd(tlg_pkg::OP_READ, 100, 5, 1'b0);
        add_cmd(tlg_pkg::OP_NONE, 127, 127, 1'b1);
        add_cmd(tlg_pkg::OP_READ, 0, 0, 1'b0);
        add_cmd(tlg_pkg::OP_WRITE, 0, 0, 1'b0);
        // blinker in the middle
        add_cmd(tlg_pkg::OP_WRITE, 50, 49, 1'b1);
        add_cmd(tlg_pkg::OP_WRITE, 50, 50, 1'b1);
        add_cmd(tlg_pkg::OP_WRITE, 50, 51, 1'b1);
        add_cmd(tlg_pkg::OP_ADVANCE, 0, 0, 1'b0);
        add_cmd(tlg_pkg::OP_READ, 49, 50, 1'b0);
        add_cmd(tlg_pkg::OP_READ, 50, 50, 1'b0);
        add_cmd(tlg_pkg::OP_READ, 51, 50, 1'b0);
        add_cmd(tlg_pkg::OP_READ, 50, 49, 1'b0);
        // blinker across the wrap in rows
        add_cmd(tlg_pkg::OP_WRITE, 99, 0, 1'b1);
        add_cmd(tlg_pkg::OP_WRITE, 0, 0, 1'b1);
        add_cmd(tlg_pkg::OP_WRITE, 1, 0, 1'b1);
        add_cmd(tlg_pkg::OP_ADVANCE, 127, 127, 1'b1);
        add_cmd(tlg_pkg::OP_READ, 0, 99, 1'b0);
        add_cmd(tlg_pkg::OP_READ, 0, 1, 1'b0);
        add_cmd(tlg_pkg::OP_READ, 99, 99, 1'b0);
        drain_grid();

        set_size(128, 128);
        add_cmd(tlg_pkg::OP_WRITE, 120, 7, 1'b1);
        queue_random(8);
        drain_grid();

        // shrunk grid must leave the far cell alone
        set_size(4, 4);
        add_cmd(tlg_pkg::OP_ADVANCE, 0, 0, 1'b0);
        queue_random(8);
        drain_grid();

        set_size(128, 128);
        add_cmd(tlg_pkg::OP_READ, 120, 7, 1'b0);
        queue_random(6);
        drain_grid();

        set_size(1, 1);
        queue_random(7);
        drain_grid();

        set_size(2, 2);
        queue_random(7);
        drain_grid();

        set_size(1, 128);
        queue_random(7);
        drain_grid();

        set_size(128, 2);
        queue_random(7);
        drain_grid();

        // zero taken as one
        set_size(0, 0);
        queue_random(6);
        drain_grid();

        // above bound taken as the bound
        set_size(200, 255);
        queue_random(6);
        drain_grid();

        calm = 1'b1;
        set_size(6, 7);
        queue_random(10);
        drain_grid();

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/tlg_pkg.sv
src/tlg_row_eval.sv
src/toroidal_life_generation_engine_unit.sv
src/tlg_checker.sv
bench/testbench.sv
